>>> src/sbbd_pkg.sv
package sbbd_pkg;

	localparam int BIN_W      = 3;
	localparam int POWER_W    = 8;
	localparam int PEAK_W     = 10;
	localparam int INTEN_W    = 9;
	localparam int TENTHS_W   = 4;
	localparam int CFG_W      = 9;
	localparam int LOG_FRAC_W = 12;
	localparam int LOG_INT_W  = 4;
	localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
	localparam int MANT_W     = 16;
	localparam int QUOT_W     = 12;
	// log2(power) < 8.0, so its top bit is always zero
	localparam int DIVD_W     = LOG_W - 1 + 8;
	localparam int STEP_W     = 4;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [PEAK_W-1:0]   PEAK_RESET     = 10'd3;
	localparam logic [INTEN_W-1:0]  FULL_Q8        = 9'd256;
	localparam logic [TENTHS_W-1:0] TENTHS_RESET   = 4'd7;
	localparam logic [INTEN_W-1:0]  MIN_INTEN_RESET = 9'd51;

	typedef enum logic [0:0] {
		REG_TRIGGER_TENTHS = 1'b0,
		REG_MIN_INTENSITY  = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_TRACK = 5'b00010,
		ST_LOG   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	typedef struct packed {
		logic              done;
		logic              beat;
		logic [PEAK_W-1:0] peak;
	} trk_res_t;

endpackage

>>> src/sbbd_bin_track.sv
module sbbd_bin_track #(
	parameter int NUM_BINS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sbbd_pkg::BIN_W-1:0]       bin_index,
	input  logic [sbbd_pkg::POWER_W-1:0]     sound_power,
	input  logic [sbbd_pkg::TENTHS_W-1:0]    trigger_tenths,
	output sbbd_pkg::trk_res_t               res
);
	import sbbd_pkg::*;

	// a 3-bit index reaches at most eight bins
	localparam int DEPTH = (NUM_BINS < (1 << BIN_W)) ? NUM_BINS : (1 << BIN_W);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PEAK_W-1:0]  peak_q  [DEPTH];
	logic [POWER_W-1:0] floor_q [DEPTH];
	logic [POWER_W-1:0] last_q  [DEPTH];
	logic [POWER_W-1:0] older_q [DEPTH];

	logic               valid_s1, valid_s2;
	logic [BIN_W-1:0]   bin_s1, bin_s2;
	logic [POWER_W-1:0] power_s1, power_s2;
	logic [PEAK_W-1:0]  peak_s2;
	logic [POWER_W-1:0] mn_s2;
	logic               inr_s1, inr_s2;

	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [PEAK_W-1:0]  peak_rd, peak_upd;
	logic [POWER_W-1:0] floor_rd, last_rd, older_rd, mn_upd;
	logic               local_max;
	logic [11:0]        peak_sum;
	logic [POWER_W-1:0] diff;
	logic [11:0]        lhs;
	logic [13:0]        rhs;
	logic               beat;
	trk_res_t           res_q;

	assign idx_s1 = bin_s1[IDX_W-1:0];
	assign idx_s2 = bin_s2[IDX_W-1:0];
	assign inr_s1 = (32'(bin_s1) < NUM_BINS);

	assign peak_rd  = peak_q[idx_s1];
	assign floor_rd = floor_q[idx_s1];
	assign last_rd  = last_q[idx_s1];
	assign older_rd = older_q[idx_s1];

	// previous power was a local maximum
	assign local_max = ((9'(power_s1) + 9'(peak_rd[PEAK_W-1:2])) < 9'(last_rd))
		&& (last_rd > older_rd);

	// 12-bit sum shifted by two never exceeds 1023, so the peak saturates by itself
	assign peak_sum = 12'({peak_rd, 1'b0}) + 12'(peak_rd)
		+ (({2'b00, last_rd} > peak_rd) ? 12'({last_rd, 1'b0}) : 12'(last_rd));
	assign peak_upd = local_max ? peak_sum[11:2] : peak_rd;

	always_comb begin
		if (power_s1 < floor_rd)
			mn_upd = power_s1;
		else if (floor_rd != '0)
			mn_upd = floor_rd - 1'b1;
		else
			mn_upd = floor_rd;
	end

	assign diff = power_s2 - mn_s2;
	assign lhs  = 12'({diff, 3'b000}) + 12'({diff, 1'b0});
	assign rhs  = 14'(trigger_tenths) * 14'(peak_s2);
	assign beat = (power_s2 > mn_s2) && ({2'b00, lhs} > rhs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_q    <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				peak_q[i]  <= PEAK_RESET;
				floor_q[i] <= '0;
				last_q[i]  <= '0;
				older_q[i] <= '0;
			end
		end else begin
			valid_s1   <= start;
			valid_s2   <= valid_s1;
			res_q.done <= valid_s2;
			if (valid_s1 && inr_s1) begin
				peak_q[idx_s1]  <= peak_upd;
				last_q[idx_s1]  <= power_s1;
				older_q[idx_s1] <= last_rd;
			end
			if (valid_s2) begin
				res_q.beat <= inr_s2 && beat;
				res_q.peak <= inr_s2 ? peak_s2 : '0;
				if (inr_s2)
					floor_q[idx_s2] <= beat ? power_s2 : mn_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_s1   <= bin_index;
			power_s1 <= sound_power;
		end
		if (valid_s1) begin
			bin_s2   <= bin_s1;
			power_s2 <= power_s1;
			inr_s2   <= inr_s1;
			peak_s2  <= peak_upd;
			mn_s2    <= mn_upd;
		end
	end

	assign res = res_q;

endmodule

>>> src/sbbd_log2.sv
module sbbd_log2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sbbd_pkg::PEAK_W-1:0]   x,
	output logic                          done,
	output logic [sbbd_pkg::LOG_W-1:0]    result
);
	import sbbd_pkg::*;

	logic [LOG_INT_W-1:0]  n, n_q;
	logic [MANT_W-1:0]     mant, y_q;
	logic [LOG_FRAC_W-1:0] frac_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  done_q;
	logic [31:0]           sq;
	logic [16:0]           t;
	logic                  busy;

	// leading one position
	always_comb begin
		n = '0;
		for (int i = 1; i < PEAK_W; i++)
			if (x[i])
				n = LOG_INT_W'(i);
	end

	assign mant = {{(MANT_W-PEAK_W){1'b0}}, x} << (LOG_INT_W'(MANT_W - 1) - n);
	assign busy = (cnt_q != '0);
	assign sq   = 32'(y_q) * 32'(y_q);
	assign t    = sq[31:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == STEP_W'(1));
			if (start)
				cnt_q <= STEP_W'(LOG_FRAC_W);
			else if (busy)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// one fraction bit per squaring step
	always_ff @(posedge clk) begin
		if (start) begin
			y_q    <= mant;
			n_q    <= n;
			frac_q <= '0;
		end else if (busy) begin
			y_q    <= t[16] ? t[16:1] : t[15:0];
			frac_q <= {frac_q[LOG_FRAC_W-2:0], t[16]};
		end
	end

	assign done   = done_q;
	assign result = {n_q, frac_q};

endmodule

>>> src/sbbd_div.sv
module sbbd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sbbd_pkg::DIVD_W-1:0]    dividend,
	input  logic [sbbd_pkg::LOG_W-1:0]     divisor,
	output logic                           done,
	output logic [sbbd_pkg::QUOT_W-1:0]    quotient
);
	import sbbd_pkg::*;

	logic [LOG_W-1:0]  rem_q, div_q;
	logic [QUOT_W-1:0] dq_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [LOG_W:0]    t, t_sub;
	logic              ge;
	logic              busy;

	assign busy  = (cnt_q != '0);
	assign t     = {rem_q, dq_q[QUOT_W-1]};
	assign t_sub = t - {1'b0, div_q};
	assign ge    = (t >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == STEP_W'(1));
			if (start)
				cnt_q <= STEP_W'(QUOT_W);
			else if (busy)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring division, dividend bits leave at the top while quotient bits enter below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= LOG_W'(dividend[DIVD_W-1:QUOT_W]);
			dq_q  <= dividend[QUOT_W-1:0];
			div_q <= divisor;
		end else if (busy) begin
			rem_q <= ge ? t_sub[LOG_W-1:0] : t[LOG_W-1:0];
			dq_q  <= {dq_q[QUOT_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

>>> src/spectral_bin_beat_detector_top.sv
// an input transaction runs through the bin tracker to a result when no intensity is computed;
// a beat whose intensity needs the logarithm ratio also runs the 12-step log2 squaring lanes
// and then the 12-step restoring divider; a new input is taken only after the result of the
// last one has been loaded into the output register, which holds while m_tready is low
// reset: asynchronous; every bin peak returns to 3, minimum and powers to 0,
// trigger_tenths to 7 and min_intensity_q8 to 51
module spectral_bin_beat_detector_top #(
	parameter int NUM_BINS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sbbd_pkg::IN_DATA_W-1:0]    s_tdata,   // bin_index, sound_power
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sbbd_pkg::OUT_DATA_W-1:0]   m_tdata,   // beat, intensity_q8, peak_out
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [sbbd_pkg::CFG_W-1:0]        cfg_data
);
	import sbbd_pkg::*;

	state_t                state_q;
	logic [TENTHS_W-1:0]   tenths_q;
	logic [INTEN_W-1:0]    min_inten_q;
	logic [POWER_W-1:0]    power_q;
	logic                  beat_q;
	logic [PEAK_W-1:0]     peak_q;
	logic [INTEN_W-1:0]    inten_q;
	logic                  use_ratio_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic                  accept;
	trk_res_t              trk;
	logic                  small_ops;
	logic                  log_start, div_start, fin_load;
	logic                  lp_done, lk_done;
	logic [LOG_W-1:0]      lp, lk;
	logic                  div_done;
	logic [QUOT_W-1:0]     ratio;
	logic [INTEN_W-1:0]    f, one_minus_f;
	logic [20:0]           prod;
	logic [13:0]           scaled_sum;
	logic [INTEN_W-1:0]    scaled, inten_out;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign small_ops = (power_q <= POWER_W'(1)) || (trk.peak <= PEAK_W'(1));
	assign log_start = (state_q == ST_TRACK) && trk.done && trk.beat && !small_ops;
	assign div_start = (state_q == ST_LOG) && lp_done && lk_done;
	assign fin_load  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	sbbd_bin_track #(
		.NUM_BINS(NUM_BINS)
	) u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (accept),
		.bin_index      (s_tdata[BIN_W-1:0]),
		.sound_power    (s_tdata[BIN_W+POWER_W-1:BIN_W]),
		.trigger_tenths (tenths_q),
		.res            (trk)
	);

	sbbd_log2 u_log_power (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      ({2'b00, power_q}),
		.done   (lp_done),
		.result (lp)
	);

	sbbd_log2 u_log_peak (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (trk.peak),
		.done   (lk_done),
		.result (lk)
	);

	sbbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({lp[LOG_W-2:0], 8'd0}),
		.divisor  (lk),
		.done     (div_done),
		.quotient (ratio)
	);

	// floor above full counts as full
	assign f           = (min_inten_q > FULL_Q8) ? FULL_Q8 : min_inten_q;
	assign one_minus_f = FULL_Q8 - f;
	assign prod        = 21'(ratio) * 21'(one_minus_f);
	assign scaled_sum  = 14'(f) + 14'(prod[20:8]);
	assign scaled      = (scaled_sum > 14'(FULL_Q8)) ? FULL_Q8 : scaled_sum[INTEN_W-1:0];
	assign inten_out   = use_ratio_q ? scaled : inten_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tenths_q    <= TENTHS_RESET;
			min_inten_q <= MIN_INTEN_RESET;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_TRIGGER_TENTHS: tenths_q    <= cfg_data[TENTHS_W-1:0];
					REG_MIN_INTENSITY:  min_inten_q <= cfg_data[INTEN_W-1:0];
					default: ;
				endcase
			end

			if (fin_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_TRACK;
				end
				ST_TRACK: begin
					if (trk.done)
						state_q <= log_start ? ST_LOG : ST_FIN;
				end
				ST_LOG: begin
					if (div_start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			power_q <= s_tdata[BIN_W+POWER_W-1:BIN_W];
		if ((state_q == ST_TRACK) && trk.done) begin
			beat_q      <= trk.beat;
			peak_q      <= trk.peak;
			use_ratio_q <= 1'b0;
			inten_q     <= !trk.beat ? '0 : FULL_Q8;
		end
		if ((state_q == ST_DIV) && div_done)
			use_ratio_q <= 1'b1;
		if (fin_load)
			m_tdata_q <= {4'd0, peak_q, inten_out, beat_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> src/sbbd_checker.sv
module sbbd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sbbd_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import sbbd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in flight: input closes right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// no beat means zero intensity
	a_no_beat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || (m_tdata[9:1] == '0)))
		else $error("intensity without beat");

	// intensity never above full scale
	a_inten_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:1] <= FULL_Q8))
		else $error("intensity above full");

endmodule

bind spectral_bin_beat_detector_top sbbd_checker u_sbbd_checker (.*);
